>>> hw/rtl/suffix_interval_narrowing_unit_assert.svh
// Assertion macros for the suffix interval narrowing unit.
`ifndef SUFFIX_INTERVAL_NARROWING_UNIT_ASSERT_SVH
`define SUFFIX_INTERVAL_NARROWING_UNIT_ASSERT_SVH
// Implication checked on every clock outside reset.
`define SIN_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define SIN_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

>>> hw/rtl/sin_pkg.sv
// Shared types and constants of the suffix interval narrowing unit.
package sin_pkg;
   localparam int TextDepth = 65536;
   localparam int TextAw = 16;
   localparam int SufAw = 16;

   localparam logic [1:0] KIND_TEXT  = 2'd0;
   localparam logic [1:0] KIND_SUF   = 2'd1;
   localparam logic [1:0] KIND_QUERY = 2'd2;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] address;
      logic [15:0] write_value;
      logic [7:0]  query_symbol;
      logic [15:0] match_depth;
      logic [15:0] interval_start;
      logic [15:0] interval_end;
   } req_type;

   typedef struct packed {
      logic [16:0] new_start;
      logic [15:0] new_end;
      logic        found;
   } rsp_type;

   // Datapath operations issued by the controller.
   typedef enum logic [3:0] {
      OP_NONE, OP_LOAD, OP_WRITE, OP_RD_SUF, OP_RD_TXT, OP_FIRST, OP_LAST,
      OP_LPROBE, OP_LDONE, OP_RPROBE, OP_DONE
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [16:0] probe_rank;
   } cmd_type;

   typedef struct packed {
      logic is_query;
      logic is_write;
      logic reversed;
      logic early;      // empty below or above after first/last reads
      logic sym_eq_first;
      logic sym_eq_last;
      logic hit;
      logic l_more;     // left search needs another probe
      logic r_more;
      logic [16:0] l_mid;
      logic [16:0] r_mid;
      logic [15:0] start_r;
      logic [15:0] end_r;
   } sts_type;
endpackage

>>> hw/rtl/sin_ram.sv
// Generic single-port RAM with registered read.
module sin_ram #(
   parameter int Width = 8,
   parameter int Depth = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wdata,
   output logic [Width-1:0]         rdata
);
   logic [Width-1:0] mem [Depth];
   always_ff @(posedge clock) begin
      if (we) mem[addr] <= wdata;
      rdata <= mem[addr];
   end
endmodule

>>> hw/rtl/sin_datapath.sv
// Datapath: stores, search bounds and result register.
module sin_datapath import sin_pkg::*; (
   input  logic        clock,
   input  logic        csr_we,
   input  logic [16:0] csr_wdata,
   input  logic        reset,
   input  req_type     req_in,
   input  cmd_type     cmd,
   output sts_type     sts,
   output rsp_type     rsp_data
);
   req_type     req_ff;
   logic [16:0] len_ff;
   logic [16:0] lo_ff, hi_ff, rlo_ff, rhi_ff;
   logic [7:0]  first_ff, last_ff;
   logic        hit_ff;
   rsp_type     out_ff;
   logic [15:0] suf_rd;
   logic [7:0]  txt_rd;
   logic [15:0] suf_addr, txt_addr;
   logic [16:0] pos;
   logic        pos_ok;
   logic [7:0]  sym_s;
   logic        t_we, s_we;

   assign t_we = cmd.op == OP_WRITE && req_ff.kind == KIND_TEXT;
   assign s_we = cmd.op == OP_WRITE && req_ff.kind == KIND_SUF;
   assign suf_addr = s_we ? req_ff.address : cmd.probe_rank[15:0];
   assign pos = {1'b0, suf_rd} + {1'b0, req_ff.match_depth};
   assign txt_addr = t_we ? req_ff.address : pos[15:0];

   sin_ram #(.Width(16), .Depth(65536)) u_suf (
      .clock, .we(s_we), .addr(suf_addr), .wdata(req_ff.write_value), .rdata(suf_rd));
   sin_ram #(.Width(8), .Depth(TextDepth)) u_txt (
      .clock, .we(t_we), .addr(txt_addr), .wdata(req_ff.write_value[7:0]),
      .rdata(txt_rd));

   // Position check captured with the text read.
   always_ff @(posedge clock) begin
      if (cmd.op == OP_RD_TXT) pos_ok <= pos < len_ff && pos[16] == 1'b0;
   end
   assign sym_s = pos_ok ? txt_rd : 8'd0;

   always_ff @(posedge clock) begin
      if (reset) len_ff <= 17'd65536;
      else if (csr_we) len_ff <= csr_wdata;
   end

   always_ff @(posedge clock) begin
      unique case (cmd.op)
         OP_LOAD: begin
            req_ff <= req_in;
            hit_ff <= 1'b0;
         end
         OP_FIRST: first_ff <= sym_s;
         OP_LAST: begin
            last_ff <= sym_s;
            lo_ff  <= {1'b0, req_ff.interval_start};
            hi_ff  <= {1'b0, req_ff.interval_end};
            rlo_ff <= {1'b0, req_ff.interval_start};
            rhi_ff <= {1'b0, req_ff.interval_end};
            if (req_ff.query_symbol == first_ff) hit_ff <= 1'b1;
         end
         OP_LPROBE: begin
            if (req_ff.query_symbol <= sym_s) begin
               if (!hit_ff && req_ff.query_symbol == sym_s) begin
                  hit_ff <= 1'b1;
                  rlo_ff <= cmd.probe_rank;
                  rhi_ff <= hi_ff;
               end
               hi_ff <= cmd.probe_rank;
            end else lo_ff <= cmd.probe_rank;
         end
         OP_LDONE: begin
            if (!hit_ff || req_ff.query_symbol != first_ff) lo_ff <= hi_ff;
            if (req_ff.query_symbol == last_ff) rlo_ff <= {1'b0, req_ff.interval_end};
            else if (!hit_ff) rlo_ff <= hi_ff - 17'd1;
         end
         OP_RPROBE: begin
            if (req_ff.query_symbol < sym_s) rhi_ff <= cmd.probe_rank;
            else rlo_ff <= cmd.probe_rank;
         end
         OP_DONE: begin
            if (req_ff.interval_start > req_ff.interval_end) begin
               out_ff.new_start <= {1'b0, req_ff.interval_start};
               out_ff.new_end   <= req_ff.interval_end;
               out_ff.found     <= 1'b0;
            end else if (req_ff.query_symbol < first_ff) begin
               out_ff.new_start <= {1'b0, req_ff.interval_start} + 17'd1;
               out_ff.new_end   <= req_ff.interval_start;
               out_ff.found     <= 1'b0;
            end else if (req_ff.query_symbol > last_ff) begin
               out_ff.new_start <= {1'b0, req_ff.interval_end} + 17'd1;
               out_ff.new_end   <= req_ff.interval_end;
               out_ff.found     <= 1'b0;
            end else begin
               out_ff.new_start <= lo_ff;
               out_ff.new_end   <= rlo_ff[15:0];
               out_ff.found     <= lo_ff <= rlo_ff;
            end
         end
         default: ;
      endcase
   end

   logic [16:0] lsum, rsum;
   assign lsum = lo_ff + hi_ff;
   assign rsum = rlo_ff + rhi_ff;

   assign sts.is_query     = req_ff.kind == KIND_QUERY;
   assign sts.is_write     = req_ff.kind == KIND_TEXT || req_ff.kind == KIND_SUF;
   assign sts.reversed     = req_ff.interval_start > req_ff.interval_end;
   assign sts.early        = req_ff.query_symbol < first_ff ||
                             req_ff.query_symbol > last_ff;
   assign sts.sym_eq_first = req_ff.query_symbol == first_ff;
   assign sts.sym_eq_last  = req_ff.query_symbol == last_ff;
   assign sts.hit          = hit_ff;
   assign sts.l_more       = hi_ff > lo_ff + 17'd1;
   assign sts.r_more       = rhi_ff > rlo_ff + 17'd1;
   assign sts.l_mid        = {1'b0, lsum[16:1]};
   assign sts.r_mid        = {1'b0, rsum[16:1]};
   assign sts.start_r      = req_ff.interval_start;
   assign sts.end_r        = req_ff.interval_end;
   assign rsp_data = out_ff;
endmodule

>>> hw/rtl/sin_ctrl.sv
// Controller: sequences store writes, boundary reads and both searches.
module sin_ctrl import sin_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   output logic    rsp_valid,
   input  sts_type sts,
   output cmd_type cmd
);
   typedef enum logic [10:0] {
      S_IDLE  = 11'b00000000001,
      S_DISP  = 11'b00000000010,
      S_SUF   = 11'b00000000100,
      S_TXT   = 11'b00000001000,
      S_CAP   = 11'b00000010000,
      S_CHK   = 11'b00000100000,
      S_LDONE = 11'b00001000000,
      S_RSEL  = 11'b00010000000,
      S_DONE  = 11'b00100000000,
      S_OUT   = 11'b01000000000,
      S_LSEL  = 11'b10000000000
   } state_type;
   // Which read the S_SUF..S_CAP sequence serves.
   typedef enum logic [1:0] {P_FIRST, P_LAST, P_LEFT, P_RIGHT} phase_type;

   state_type   state_ff, state_in;
   phase_type   phase_ff, phase_in;
   logic [16:0] rank_ff, rank_in;

   assign busy = state_ff != S_IDLE;
   assign rsp_valid = state_ff == S_OUT;

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      rank_in  = rank_ff;
      cmd.op = OP_NONE;
      cmd.probe_rank = rank_ff;
      unique case (state_ff)
         S_IDLE: if (start) begin
            cmd.op = OP_LOAD;
            state_in = S_DISP;
         end
         S_DISP: begin
            if (sts.is_write) begin
               cmd.op = OP_WRITE;
               state_in = S_IDLE;
            end else if (!sts.is_query) state_in = S_IDLE;
            else if (sts.reversed) state_in = S_DONE;
            else begin
               rank_in = {1'b0, sts.start_r};
               phase_in = P_FIRST;
               state_in = S_SUF;
            end
         end
         S_SUF: begin
            cmd.op = OP_RD_SUF;
            state_in = S_TXT;
         end
         S_TXT: begin
            cmd.op = OP_RD_TXT;
            state_in = S_CAP;
         end
         S_CAP: begin
            unique case (phase_ff)
               P_FIRST: begin
                  cmd.op = OP_FIRST;
                  rank_in = {1'b0, sts.end_r};
                  phase_in = P_LAST;
                  state_in = S_SUF;
               end
               P_LAST: begin
                  cmd.op = OP_LAST;
                  state_in = S_CHK;
               end
               P_LEFT: begin
                  cmd.op = OP_LPROBE;
                  state_in = S_LSEL;
               end
               default: begin
                  cmd.op = OP_RPROBE;
                  state_in = S_RSEL;
               end
            endcase
         end
         S_CHK: begin
            if (sts.early) state_in = S_DONE;
            else if (sts.sym_eq_first) state_in = S_LDONE;
            else state_in = S_LSEL;
         end
         S_LSEL: begin
            if (sts.l_more) begin
               rank_in = sts.l_mid;
               phase_in = P_LEFT;
               state_in = S_SUF;
            end else state_in = S_LDONE;
         end
         S_LDONE: begin
            cmd.op = OP_LDONE;
            state_in = sts.sym_eq_last ? S_DONE : S_RSEL;
         end
         S_RSEL: begin
            if (sts.r_more) begin
               rank_in = sts.r_mid;
               phase_in = P_RIGHT;
               state_in = S_SUF;
            end else state_in = S_DONE;
         end
         S_DONE: begin
            cmd.op = OP_DONE;
            state_in = S_OUT;
         end
         S_OUT: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         phase_ff <= P_FIRST;
         rank_ff  <= '0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         rank_ff  <= rank_in;
      end
   end

`include "suffix_interval_narrowing_unit_assert.svh"
   `SIN_ASSERT_NXT(a_out_idle, clock, reset, rsp_valid, !rsp_valid)
   `SIN_ASSERT_NXT(a_done_out, clock, reset, cmd.op == OP_DONE, rsp_valid)
   `SIN_ASSERT_IMP(a_busy_out, clock, reset, rsp_valid, busy)
endmodule

>>> hw/rtl/suffix_interval_narrowing_unit.sv
// Top level of the suffix interval narrowing unit.
// channel | ports                         | handshake
// request | start, busy, req_data         | taken when start && !busy
// result  | rsp_valid, rsp_data           | one-cycle strobe, no stall
// config  | csr_we, csr_wdata             | written when csr_we
// A reversed query skips the boundary reads and searches; any other query makes up to
// 16 probes per search, each probe a dependent suffix read then text read.
// Reset is synchronous; busy stays high until the result strobe of a query has passed.
// The receiver cannot stall, so results leave on their single strobe cycle.
module suffix_interval_narrowing_unit import sin_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_data,
   output logic        rsp_valid,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [16:0] csr_wdata
);
   cmd_type cmd;
   sts_type sts;
   sin_ctrl u_ctrl (.clock, .reset, .start, .busy, .rsp_valid, .sts, .cmd);
   sin_datapath u_dp (.clock, .csr_we, .csr_wdata, .reset, .req_in(req_data),
      .cmd, .sts, .rsp_data);
endmodule
